/* rtl/core/pclip_pkg.sv */
// ----------------------------------------------------------------------------
// pclip_pkg - shared definitions for the half-plane polygon clipper
// Widths, register map, count cap and the command/status bundles that pass
// between the clip controller and its datapath.
// ----------------------------------------------------------------------------
package pclip_pkg;

  // Polygon and fixed-point format
  localparam int MAX_VERTS = 64;
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int COORD_W = 32;
  localparam int NORM_W  = 18;
  localparam int OFFS_W  = 32;
  localparam int CNT_W   = 8;

  // Plane distance: x*nx + y*ny, floor-shifted, minus offset
  localparam int PROD_W = COORD_W + NORM_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QUOT_W = SUM_W - FRAC_BITS;
  localparam int DIST_W = ((QUOT_W > OFFS_W) ? QUOT_W : OFFS_W) + 1;

  // Crossing ratio t = |da| * 2^T_BITS / (|da| + |db|)
  localparam int DIV_W      = DIST_W + 1;
  localparam int T_BITS     = 30;
  localparam int STEP_CNT_W = $clog2(T_BITS);

  // Interpolation: |b - a| * t split into two partial products
  localparam int MAG_W   = COORD_W + 1;
  localparam int T_LO    = T_BITS / 2;
  localparam int T_HI    = T_BITS - T_LO;
  localparam int PP_LO_W = MAG_W + T_LO;
  localparam int PP_HI_W = MAG_W + T_HI;
  localparam int PSUM_W  = MAG_W + T_BITS;
  localparam int LERP_W  = MAG_W + 1;

  // Saturating vertex count
  localparam int COUNT_CAP_I = ((2 * MAX_VERTS) > 255) ? 255 : (2 * MAX_VERTS);

  // Configuration port
  localparam int APB_DW    = 32;
  localparam int NUM_REGS  = 3;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int APB_AW    = REG_IDX_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [OFFS_W-1:0]  offs_t;
  typedef logic signed [DIST_W-1:0]  dist_t;
  typedef logic        [CNT_W-1:0]   cnt_t;

  localparam cnt_t  COUNT_CAP      = CNT_W'(COUNT_CAP_I);
  localparam norm_t NORMAL_Y_RESET = NORM_W'(1 << FRAC_BITS);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_PLANE_OFFSET = 2'd2
  } reg_idx_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;
    logic calc_mul;
    logic calc_sum;
    logic calc_dist;
    logic set_first;
    logic edge_open;
    logic edge_close;
    logic advance;
    logic emit_a;
    logic div_init;
    logic div_step;
    logic lerp_diff;
    logic lerp_mul;
    logic lerp_sum;
    logic lerp_add;
    logic emit_c;
    logic emit_end;
  } pclip_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_first;
    logic in_final;
    logic a_inside;
    logic crossing;
    logic out_free;
    logic axis_y;
  } pclip_sts_t;

endpackage

/* rtl/core/pclip_if.sv */
// ----------------------------------------------------------------------------
// pclip_if - valid/ready channels of the half-plane polygon clipper
// Vertex input channel and clipped-vertex result channel.
// ----------------------------------------------------------------------------
interface pclip_in_if;
  import pclip_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   first_vertex;
  logic   final_vertex;

  modport source (output valid, output vertex_x, output vertex_y,
                  output first_vertex, output final_vertex, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y,
                  input first_vertex, input final_vertex, output ready);
endinterface

interface pclip_out_if;
  import pclip_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  logic   is_end;
  cnt_t   out_count;

  modport source (output valid, output out_x, output out_y,
                  output is_end, output out_count, input ready);
  modport sink   (input valid, input out_x, input out_y,
                  input is_end, input out_count, output ready);
endinterface

/* rtl/core/pclip_ctrl.sv */
// ----------------------------------------------------------------------------
// pclip_ctrl - clip sequencer
// Walks one vertex item through distance, open edge, closing edge and end
// marker, and drives the divider step count.
// ----------------------------------------------------------------------------
module pclip_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pclip_pkg::pclip_sts_t sts,
  output pclip_pkg::pclip_cmd_t cmd
);
  import pclip_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE     = 17'h00001,
    ST_MUL      = 17'h00002,
    ST_SUM      = 17'h00004,
    ST_DIST     = 17'h00008,
    ST_ROUTE    = 17'h00010,
    ST_EDGE     = 17'h00020,
    ST_EMIT_A   = 17'h00040,
    ST_XCHK     = 17'h00080,
    ST_DIV_INIT = 17'h00100,
    ST_DIV      = 17'h00200,
    ST_LDIFF    = 17'h00400,
    ST_LMUL     = 17'h00800,
    ST_LSUM     = 17'h01000,
    ST_LADD     = 17'h02000,
    ST_EMIT_C   = 17'h04000,
    ST_ADVANCE  = 17'h08000,
    ST_END      = 17'h10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  close_r, close_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    close_nxt = close_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.calc_mul = 1'b1;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        cmd.calc_sum = 1'b1;
        state_nxt    = ST_DIST;
      end
      ST_DIST: begin
        cmd.calc_dist = 1'b1;
        state_nxt     = ST_ROUTE;
      end
      ST_ROUTE: begin
        if (sts.in_first) begin
          cmd.set_first = 1'b1;
          state_nxt     = ST_ADVANCE;
        end else begin
          cmd.edge_open = 1'b1;
          close_nxt     = 1'b0;
          state_nxt     = ST_EDGE;
        end
      end
      ST_EDGE: begin
        state_nxt = sts.a_inside ? ST_EMIT_A : ST_XCHK;
      end
      ST_EMIT_A: begin
        if (sts.out_free) begin
          cmd.emit_a = 1'b1;
          state_nxt  = ST_XCHK;
        end
      end
      ST_XCHK: begin
        if (sts.crossing) begin
          state_nxt = ST_DIV_INIT;
        end else begin
          state_nxt = close_r ? ST_END : ST_ADVANCE;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = STEP_CNT_W'(T_BITS - 1);
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_LDIFF;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_LDIFF: begin
        cmd.lerp_diff = 1'b1;
        state_nxt     = ST_LMUL;
      end
      ST_LMUL: begin
        cmd.lerp_mul = 1'b1;
        state_nxt    = ST_LSUM;
      end
      ST_LSUM: begin
        cmd.lerp_sum = 1'b1;
        state_nxt    = ST_LADD;
      end
      ST_LADD: begin
        cmd.lerp_add = 1'b1;
        state_nxt    = sts.axis_y ? ST_EMIT_C : ST_LDIFF;
      end
      ST_EMIT_C: begin
        if (sts.out_free) begin
          cmd.emit_c = 1'b1;
          state_nxt  = close_r ? ST_END : ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        cmd.advance = 1'b1;
        if (sts.in_final) begin
          cmd.edge_close = 1'b1;
          close_nxt      = 1'b1;
          state_nxt      = ST_EDGE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_END: begin
        if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      close_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      close_r <= close_nxt;
    end
  end

  // Results are only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_a || cmd.emit_c || cmd.emit_end) |-> sts.out_free)
    else $error("result loaded while output register busy");

  // Divider only starts on a real crossing
  a_div_cross: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> sts.crossing)
    else $error("divider started without a crossing");

  // Closing edge only for a final vertex
  a_close_final: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.edge_close |-> sts.in_final)
    else $error("closing edge without final vertex");

endmodule

/* rtl/core/pclip_dp.sv */
// ----------------------------------------------------------------------------
// pclip_dp - clip datapath
// Plane distance, vertex history, restoring divider for the crossing ratio,
// split-product interpolation, vertex count and the output register.
// ----------------------------------------------------------------------------
module pclip_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pclip_pkg::pclip_cmd_t cmd,
  output pclip_pkg::pclip_sts_t sts,
  input  pclip_pkg::coord_t     vert_x,
  input  pclip_pkg::coord_t     vert_y,
  input  logic                  vert_first,
  input  logic                  vert_final,
  input  pclip_pkg::norm_t      normal_x,
  input  pclip_pkg::norm_t      normal_y,
  input  pclip_pkg::offs_t      plane_offset,
  input  logic                  res_ready,
  output logic                  res_valid,
  output pclip_pkg::coord_t     res_x,
  output pclip_pkg::coord_t     res_y,
  output logic                  res_end,
  output pclip_pkg::cnt_t       res_count
);
  import pclip_pkg::*;

  // Current vertex and its distance pipeline
  coord_t                    cur_x_r, cur_y_r;
  logic                      cur_first_r, cur_final_r;
  logic signed [PROD_W-1:0]  prod_x_r, prod_y_r;
  logic signed [SUM_W-1:0]   sum_r;
  dist_t                     cur_d_r;

  // Architectural history
  coord_t first_x_r, first_y_r, prev_x_r, prev_y_r;
  dist_t  first_d_r, prev_d_r;
  cnt_t   count_r;

  // Edge operands
  coord_t a_x_r, a_y_r, b_x_r, b_y_r;
  dist_t  a_d_r, b_d_r;

  // Divider
  logic [DIV_W-1:0]  div_s_r, rem_r;
  logic [T_BITS-1:0] t_r;

  // Interpolation
  logic                axis_r;
  logic [MAG_W-1:0]    mag_r;
  logic                neg_r;
  logic [PP_LO_W-1:0]  pp_lo_r;
  logic [PP_HI_W-1:0]  pp_hi_r;
  logic [MAG_W-1:0]    step_r;
  coord_t              cx_r, cy_r;

  // Output register
  logic   out_valid_r;
  coord_t out_x_r, out_y_r;
  logic   out_end_r;
  cnt_t   out_cnt_r;

  // Combinational helpers
  logic signed [PROD_W-1:0] mul_x, mul_y;
  logic signed [SUM_W-1:0]  sum_nxt;
  dist_t                    dist_nxt;
  logic [DIST_W-1:0]        a_abs, b_abs;
  logic [DIV_W:0]           rem_sh, rem_sub;
  logic                     rem_ge;
  logic                     a_neg, a_pos, b_neg, b_pos;
  coord_t                   sel_a, sel_b;
  logic signed [MAG_W-1:0]  diff;
  logic [PSUM_W-1:0]        psum;
  logic signed [LERP_W-1:0] lerp_full;
  coord_t                   lerp_res;
  logic                     bump;

  // Plane distance: floor((x*nx + y*ny) / 2^FRAC_BITS) - offset
  assign mul_x    = PROD_W'(cur_x_r) * PROD_W'(normal_x);
  assign mul_y    = PROD_W'(cur_y_r) * PROD_W'(normal_y);
  assign sum_nxt  = SUM_W'(prod_x_r) + SUM_W'(prod_y_r);
  assign dist_nxt = DIST_W'($signed(sum_r[SUM_W-1:FRAC_BITS])) - DIST_W'(plane_offset);

  // Edge classification
  assign a_neg = a_d_r[DIST_W-1];
  assign b_neg = b_d_r[DIST_W-1];
  assign a_pos = !a_neg && (a_d_r != '0);
  assign b_pos = !b_neg && (b_d_r != '0);

  // Divider magnitudes and one restoring step
  assign a_abs   = a_neg ? DIST_W'(-a_d_r) : DIST_W'(a_d_r);
  assign b_abs   = b_neg ? DIST_W'(-b_d_r) : DIST_W'(b_d_r);
  assign rem_sh  = {rem_r, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, div_s_r};
  assign rem_sub = rem_sh - {1'b0, div_s_r};

  // Interpolation of the selected axis
  assign sel_a     = axis_r ? a_y_r : a_x_r;
  assign sel_b     = axis_r ? b_y_r : b_x_r;
  assign diff      = MAG_W'(sel_b) - MAG_W'(sel_a);
  assign psum      = (PSUM_W'(pp_hi_r) << T_LO) + PSUM_W'(pp_lo_r);
  assign lerp_full = neg_r ? (LERP_W'(sel_a) - $signed({1'b0, step_r}))
                           : (LERP_W'(sel_a) + $signed({1'b0, step_r}));
  assign lerp_res  = lerp_full[COORD_W-1:0];

  assign bump = cmd.emit_a || cmd.emit_c;

  // Status to the controller
  always_comb begin
    sts.in_first = cur_first_r;
    sts.in_final = cur_final_r;
    sts.a_inside = a_neg;
    sts.crossing = (a_neg && b_pos) || (a_pos && b_neg);
    sts.out_free = !out_valid_r || res_ready;
    sts.axis_y   = axis_r;
  end

  // Input capture and distance pipeline
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_x_r     <= vert_x;
      cur_y_r     <= vert_y;
      cur_first_r <= vert_first;
      cur_final_r <= vert_final;
    end
    if (cmd.calc_mul) begin
      prod_x_r <= mul_x;
      prod_y_r <= mul_y;
    end
    if (cmd.calc_sum) begin
      sum_r <= sum_nxt;
    end
    if (cmd.calc_dist) begin
      cur_d_r <= dist_nxt;
    end
  end

  // First/previous vertex history and vertex count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0;
      first_y_r <= '0;
      first_d_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      prev_d_r  <= '0;
      count_r   <= '0;
    end else begin
      if (cmd.set_first) begin
        first_x_r <= cur_x_r;
        first_y_r <= cur_y_r;
        first_d_r <= cur_d_r;
      end
      if (cmd.advance) begin
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
        prev_d_r <= cur_d_r;
      end
      if (cmd.set_first || cmd.emit_end) begin
        count_r <= '0;
      end else if (bump && (count_r < COUNT_CAP)) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Edge operands: open edge prev->cur, closing edge cur->first
  always_ff @(posedge clk) begin
    if (cmd.edge_open) begin
      a_x_r <= prev_x_r;
      a_y_r <= prev_y_r;
      a_d_r <= prev_d_r;
      b_x_r <= cur_x_r;
      b_y_r <= cur_y_r;
      b_d_r <= cur_d_r;
    end else if (cmd.edge_close) begin
      a_x_r <= cur_x_r;
      a_y_r <= cur_y_r;
      a_d_r <= cur_d_r;
      b_x_r <= first_x_r;
      b_y_r <= first_y_r;
      b_d_r <= first_d_r;
    end
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_s_r <= DIV_W'(a_abs) + DIV_W'(b_abs);
      rem_r   <= DIV_W'(a_abs);
      t_r     <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      t_r   <= {t_r[T_BITS-2:0], rem_ge};
    end
  end

  // Interpolation: x axis then y axis through the same unit
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      axis_r <= 1'b0;
    end else if (cmd.lerp_add) begin
      axis_r <= 1'b1;
    end
    if (cmd.lerp_diff) begin
      neg_r <= diff[MAG_W-1];
      mag_r <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end
    if (cmd.lerp_mul) begin
      pp_lo_r <= PP_LO_W'(mag_r) * PP_LO_W'(t_r[T_LO-1:0]);
      pp_hi_r <= PP_HI_W'(mag_r) * PP_HI_W'(t_r[T_BITS-1:T_LO]);
    end
    if (cmd.lerp_sum) begin
      step_r <= psum[PSUM_W-1:T_BITS];
    end
    if (cmd.lerp_add) begin
      if (axis_r) begin
        cy_r <= lerp_res;
      end else begin
        cx_r <= lerp_res;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_a || cmd.emit_c || cmd.emit_end) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_a) begin
      out_x_r   <= a_x_r;
      out_y_r   <= a_y_r;
      out_end_r <= 1'b0;
      out_cnt_r <= '0;
    end else if (cmd.emit_c) begin
      out_x_r   <= cx_r;
      out_y_r   <= cy_r;
      out_end_r <= 1'b0;
      out_cnt_r <= '0;
    end else if (cmd.emit_end) begin
      out_x_r   <= '0;
      out_y_r   <= '0;
      out_end_r <= 1'b1;
      out_cnt_r <= count_r;
    end
  end

  assign res_valid = out_valid_r;
  assign res_x     = out_x_r;
  assign res_y     = out_y_r;
  assign res_end   = out_end_r;
  assign res_count = out_cnt_r;

  // Count never passes its cap
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_CAP)
    else $error("vertex count above cap");

  // Partial remainder stays below the divisor while stepping
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < div_s_r))
    else $error("divider remainder out of range");

  // Crossing point lies between the edge endpoints
  a_lerp_between: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lerp_add |->
      ((sel_a <= sel_b) ? ((lerp_res >= sel_a) && (lerp_res <= sel_b))
                        : ((lerp_res <= sel_a) && (lerp_res >= sel_b))))
    else $error("crossing point outside edge");

endmodule

/* rtl/core/polygon_halfplane_clip.sv */
// ----------------------------------------------------------------------------
// polygon_halfplane_clip - single-plane polygon clipper, top level
// Clips a streamed polygon against dot(v, n) < offset, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one vertex item per handshake; first_vertex opens a polygon,
//   final_vertex closes it and runs the closing edge. out_ch returns inside
//   vertices and crossing points, then one end item (is_end = 1) whose
//   out_count holds the saturating vertex count.
//   The plane (normal_x, normal_y, plane_offset) is set through the APB port
//   at byte addresses 0, 4, 8; writes complete in the access cycle.
// Sequencing:
//   One vertex item at a time: an item passes through the multiply, sum,
//   distance, route and edge states before any result, and the next item is
//   accepted only after the sequencer returns to idle. Each crossing runs the
//   30-step restoring divider, then the two-axis interpolation passes. A final
//   vertex runs its open edge, then the closing edge, then the end marker.
// Reset and stalls:
//   rst_n (synchronous) clears the plane to n = (0, 1.0), offset 0, and the
//   stored vertex history and count to zero. A stalled out_ch holds its
//   item in the output register; the sequencer waits before loading the next.
// ----------------------------------------------------------------------------
module polygon_halfplane_clip (
  input  logic                        clk,
  input  logic                        rst_n,
  pclip_in_if.sink                    in_ch,
  pclip_out_if.source                 out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pclip_pkg::APB_AW-1:0] paddr,
  input  logic [pclip_pkg::APB_DW-1:0] pwdata,
  output logic [pclip_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import pclip_pkg::*;

  norm_t      normal_x_r, normal_y_r;
  offs_t      offset_r;
  reg_idx_t   reg_idx;
  logic       cfg_wr;
  pclip_cmd_t cmd;
  pclip_sts_t sts;

  // Register decode
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_x_r <= '0;
      normal_y_r <= NORMAL_Y_RESET;
      offset_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_NORMAL_X:     normal_x_r <= pwdata[NORM_W-1:0];
        REG_NORMAL_Y:     normal_y_r <= pwdata[NORM_W-1:0];
        REG_PLANE_OFFSET: offset_r   <= pwdata[OFFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back, sign-extended
  always_comb begin
    unique case (reg_idx)
      REG_NORMAL_X:     prdata = APB_DW'(normal_x_r);
      REG_NORMAL_Y:     prdata = APB_DW'(normal_y_r);
      REG_PLANE_OFFSET: prdata = APB_DW'(offset_r);
      default:          prdata = '0;
    endcase
  end

  // Sequencer
  pclip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  pclip_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .vert_x       (in_ch.vertex_x),
    .vert_y       (in_ch.vertex_y),
    .vert_first   (in_ch.first_vertex),
    .vert_final   (in_ch.final_vertex),
    .normal_x     (normal_x_r),
    .normal_y     (normal_y_r),
    .plane_offset (offset_r),
    .res_ready    (out_ch.ready),
    .res_valid    (out_ch.valid),
    .res_x        (out_ch.out_x),
    .res_y        (out_ch.out_y),
    .res_end      (out_ch.is_end),
    .res_count    (out_ch.out_count)
  );

endmodule
